// File: rtl/plru_set_assoc_cache_model_unit_assert.svh
// assertion macros for the pseudo-lru cache tag model
// used by the top level; no other dependencies
`ifndef PLRU_SET_ASSOC_CACHE_MODEL_UNIT_ASSERT_SVH
`define PLRU_SET_ASSOC_CACHE_MODEL_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PLRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plru assertion failed");
`define PLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plru assertion failed");
`else
`define PLRU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/plru_pkg.sv
// shared constants, types and tree functions of the pseudo-lru cache tag model
// no dependencies
package plru_pkg;

    // geometry
    localparam int WAYS        = 8;
    localparam int SET_BITS    = 6;
    localparam int OFFSET_BITS = 6;

    // field widths
    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 32;
    localparam int WAY_OUT_W = 4;
    localparam int CNT_W     = 32;

    // derived sizes
    localparam int NSETS  = 1 << SET_BITS;
    localparam int SET_W  = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TREE_L = $clog2(WAYS);
    localparam int TREE_N = (1 << TREE_L) - 1;
    localparam int TREE_W = (TREE_L > 0) ? TREE_N : 1;
    localparam int WAY_W  = (TREE_L > 0) ? TREE_L : 1;

    // command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [WAY_W-1:0] t_way;
    typedef logic [SET_W-1:0] t_set;

    // one set as stored in the tag ram
    typedef struct packed {
        logic [TREE_W-1:0] tree;
        logic [WAYS-1:0]   dirty;
        logic [WAYS-1:0]   valid;
        t_tag [WAYS-1:0]   tags;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    // per-access lookup outcome
    typedef struct packed {
        logic hit;
        t_way way;
        logic evicted;
        logic evicted_dirty;
        t_tag evicted_tag;
    } t_lookup;

    // counter update request
    typedef struct packed {
        logic commit;
        logic command;
        logic miss;
        logic evicted;
        logic evicted_dirty;
    } t_stat_upd;

    // running counters
    typedef struct packed {
        logic [CNT_W-1:0] rd_acc;
        logic [CNT_W-1:0] wr_acc;
        logic [CNT_W-1:0] rd_miss;
        logic [CNT_W-1:0] wr_miss;
        logic [CNT_W-1:0] clean_ev;
        logic [CNT_W-1:0] dirty_ev;
    } t_stats;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    // set index from the bits just above the block offset
    function automatic t_set get_set(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] sh;
        sh = addr >> OFFSET_BITS;
        return sh[SET_W-1:0] & SET_W'(NSETS - 1);
    endfunction

    // tag is the low bits above the set index
    function automatic t_tag get_tag(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] sh;
        sh = addr >> (OFFSET_BITS + SET_BITS);
        return sh[TAG_W-1:0];
    endfunction

    // follow the tree bits from the root down to a leaf
    function automatic t_way pick_victim(logic [TREE_W-1:0] bits);
        int   node;
        int   w;
        logic b;
        node = 0;
        w    = 0;
        for (int i = 0; i < TREE_L; i++) begin
            b    = 1'(bits >> node);
            w    = (w << 1) | int'(b);
            node = 2 * node + 1 + int'(b);
        end
        // leaf beyond the way count folds back
        if (w >= WAYS) begin
            w = w - WAYS;
        end
        return WAY_W'(w);
    endfunction

    // point every node on the path of the used way away from it
    function automatic logic [TREE_W-1:0] touch_tree(logic [TREE_W-1:0] bits, t_way w);
        logic [TREE_W-1:0] r;
        int                lvl;
        int                pre;
        int                wi;
        r  = bits;
        wi = int'(w);
        for (int n = 0; n < TREE_W; n++) begin
            if (n < TREE_N) begin
                lvl = $clog2(n + 2) - 1;
                pre = n + 1 - (1 << lvl);
                if ((wi >> (TREE_L - lvl)) == pre) begin
                    r[n] = ~1'(wi >> (TREE_L - 1 - lvl));
                end
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/plru_if.sv
// request and response channel interfaces of the pseudo-lru cache tag model
// depends on plru_pkg
interface plru_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [plru_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
endinterface

interface plru_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [plru_pkg::WAY_OUT_W-1:0] way;
    logic                           evicted;
    logic                           evicted_dirty;
    logic [plru_pkg::TAG_W-1:0]     evicted_tag;
    logic [plru_pkg::CNT_W-1:0]     read_accesses;
    logic [plru_pkg::CNT_W-1:0]     write_accesses;
    logic [plru_pkg::CNT_W-1:0]     read_misses;
    logic [plru_pkg::CNT_W-1:0]     write_misses;
    logic [plru_pkg::CNT_W-1:0]     clean_evictions;
    logic [plru_pkg::CNT_W-1:0]     dirty_evictions;

    modport source (output valid, output hit, output way, output evicted,
                    output evicted_dirty, output evicted_tag, output read_accesses,
                    output write_accesses, output read_misses, output write_misses,
                    output clean_evictions, output dirty_evictions, input ready);
    modport sink   (input valid, input hit, input way, input evicted,
                    input evicted_dirty, input evicted_tag, input read_accesses,
                    input write_accesses, input read_misses, input write_misses,
                    input clean_evictions, input dirty_evictions, output ready);
endinterface

// File: rtl/plru_ram.sv
// generic single-clock ram, one write and one read port, registered read
// no dependencies
module plru_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/plru_lookup.sv
// tag compare, fill and victim choice on one set, and the updated set
// depends on plru_pkg
module plru_lookup (
    input  plru_pkg::t_row    i_row,
    input  plru_pkg::t_tag    i_tag,
    input  logic              i_cmd,
    output plru_pkg::t_lookup o_res,
    output plru_pkg::t_row    o_row
);

    logic [plru_pkg::WAYS-1:0] hit_vec;
    logic                      any_hit;
    logic                      any_free;
    plru_pkg::t_way            hit_way;
    plru_pkg::t_way            free_way;
    plru_pkg::t_way            victim;
    plru_pkg::t_way            used;
    logic                      evict;

    // per-way tag match
    always_comb begin
        for (int w = 0; w < plru_pkg::WAYS; w++) begin
            hit_vec[w] = i_row.valid[w] && (i_row.tags[w] == i_tag);
        end
    end

    assign any_hit  = |hit_vec;
    assign any_free = ~&i_row.valid;

    // lowest matching way and lowest invalid way
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = plru_pkg::WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = plru_pkg::WAY_W'(w);
            end
            if (!i_row.valid[w]) begin
                free_way = plru_pkg::WAY_W'(w);
            end
        end
    end

    assign victim = plru_pkg::pick_victim(i_row.tree);
    assign evict  = !any_hit && !any_free;

    // way chosen for this access
    always_comb begin
        if (any_hit) begin
            used = hit_way;
        end else if (any_free) begin
            used = free_way;
        end else begin
            used = victim;
        end
    end

    // result fields
    always_comb begin
        o_res.hit           = any_hit;
        o_res.way           = used;
        o_res.evicted       = evict;
        o_res.evicted_dirty = evict && i_row.dirty[used];
        o_res.evicted_tag   = evict ? i_row.tags[used] : '0;
    end

    // updated set for write back
    always_comb begin
        o_row = i_row;
        if (any_hit) begin
            o_row.dirty[used] = i_row.dirty[used] | (i_cmd == plru_pkg::CMD_WRITE);
        end else begin
            o_row.valid[used] = 1'b1;
            o_row.tags[used]  = i_tag;
            o_row.dirty[used] = (i_cmd == plru_pkg::CMD_WRITE);
        end
        o_row.tree = plru_pkg::touch_tree(i_row.tree, used);
    end

endmodule

// File: rtl/plru_stats.sv
// running access, miss and eviction counters, wrapping
// depends on plru_pkg
module plru_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plru_pkg::t_stat_upd i_upd,
    output plru_pkg::t_stats    o_stats
);

    plru_pkg::t_stats r_stats;
    plru_pkg::t_stats n_stats;

    // next counts for one committed transaction
    always_comb begin
        n_stats = r_stats;
        if (i_upd.commit) begin
            if (i_upd.command == plru_pkg::CMD_WRITE) begin
                n_stats.wr_acc = r_stats.wr_acc + 1'b1;
                if (i_upd.miss) begin
                    n_stats.wr_miss = r_stats.wr_miss + 1'b1;
                end
            end else begin
                n_stats.rd_acc = r_stats.rd_acc + 1'b1;
                if (i_upd.miss) begin
                    n_stats.rd_miss = r_stats.rd_miss + 1'b1;
                end
            end
            if (i_upd.evicted) begin
                if (i_upd.evicted_dirty) begin
                    n_stats.dirty_ev = r_stats.dirty_ev + 1'b1;
                end else begin
                    n_stats.clean_ev = r_stats.clean_ev + 1'b1;
                end
            end
        end
    end

    // counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stats <= '0;
        end else begin
            r_stats <= n_stats;
        end
    end

    assign o_stats = r_stats;

endmodule

// File: rtl/plru_set_assoc_cache_model_unit.sv
// a transaction accepted in idle has its set row read from the tag ram; in the lookup
// state the updated row is written back and the result registered at the output
// a new transaction is taken only in idle, after the last one has written back its set row
// the lookup cycle holds while a previous result still waits at the output
// reset: counters, output valid and per-set row flags clear at once; rows never
// written read as empty with a zero tree, so no clearing pass is needed
`include "plru_set_assoc_cache_model_unit_assert.svh"

module plru_set_assoc_cache_model_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    plru_req_if.sink          i_req,
    plru_rsp_if.source        o_rsp
);

    plru_pkg::t_state                   r_state;
    plru_pkg::t_state                   n_state;
    logic                               in_ready;
    logic                               commit;

    logic                               r_cmd;
    plru_pkg::t_tag                     r_tag;
    plru_pkg::t_set                     r_set;
    logic [plru_pkg::NSETS-1:0]         r_row_vld;

    logic [plru_pkg::ROW_W-1:0]         ram_rdata;
    plru_pkg::t_row                     row_rd;
    plru_pkg::t_row                     row_wr;
    plru_pkg::t_lookup                  res;
    plru_pkg::t_stat_upd                upd;
    plru_pkg::t_stats                   stats;

    logic                               r_out_vld;
    logic                               r_hit;
    plru_pkg::t_way                     r_way;
    logic                               r_ev;
    logic                               r_evd;
    plru_pkg::t_tag                     r_evtag;

    logic                               in_acc;

    assign in_acc = i_req.valid && in_ready;

    // control state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plru_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, ready and commit
    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        commit   = 1'b0;
        case (r_state)
            plru_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) begin
                    n_state = plru_pkg::ST_LOOK;
                end
            end
            plru_pkg::ST_LOOK: begin
                if (!r_out_vld || o_rsp.ready) begin
                    commit  = 1'b1;
                    n_state = plru_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plru_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_req.ready = in_ready;

    // transaction fields held through the lookup
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_req.command;
            r_tag <= plru_pkg::get_tag(i_req.address);
            r_set <= plru_pkg::get_set(i_req.address);
        end
    end

    // set rows: tags, valid, dirty and tree bits
    plru_ram #(
        .WIDTH (plru_pkg::ROW_W),
        .DEPTH (plru_pkg::NSETS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (commit),
        .i_wr_addr (r_set),
        .i_wr_data (row_wr),
        .i_rd_en   (in_acc),
        .i_rd_addr (plru_pkg::get_set(i_req.address)),
        .o_rd_data (ram_rdata)
    );

    // rows never written since reset read as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (commit) begin
            r_row_vld[r_set] <= 1'b1;
        end
    end

    assign row_rd = r_row_vld[r_set] ? plru_pkg::t_row'(ram_rdata) : '0;

    plru_lookup u_lookup (
        .i_row (row_rd),
        .i_tag (r_tag),
        .i_cmd (r_cmd),
        .o_res (res),
        .o_row (row_wr)
    );

    // counter update
    always_comb begin
        upd.commit        = commit;
        upd.command       = r_cmd;
        upd.miss          = !res.hit;
        upd.evicted       = res.evicted;
        upd.evicted_dirty = res.evicted_dirty;
    end

    plru_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_stats (stats)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (commit) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_hit   <= res.hit;
            r_way   <= res.way;
            r_ev    <= res.evicted;
            r_evd   <= res.evicted_dirty;
            r_evtag <= res.evicted_tag;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.hit             = r_hit;
    assign o_rsp.way             = plru_pkg::WAY_OUT_W'(r_way);
    assign o_rsp.evicted         = r_ev;
    assign o_rsp.evicted_dirty   = r_evd;
    assign o_rsp.evicted_tag     = r_evtag;
    assign o_rsp.read_accesses   = stats.rd_acc;
    assign o_rsp.write_accesses  = stats.wr_acc;
    assign o_rsp.read_misses     = stats.rd_miss;
    assign o_rsp.write_misses    = stats.wr_miss;
    assign o_rsp.clean_evictions = stats.clean_ev;
    assign o_rsp.dirty_evictions = stats.dirty_ev;

    // checks
    `PLRU_ASSERT_NEXT(a_acc_to_look, i_clk, i_rst_n, in_acc, r_state == plru_pkg::ST_LOOK)
    `PLRU_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, commit, r_out_vld && r_state == plru_pkg::ST_IDLE)
    `PLRU_ASSERT_IMPL(a_ev_no_hit, i_clk, i_rst_n, r_out_vld && r_ev, !r_hit)
    `PLRU_ASSERT_IMPL(a_dirty_ev, i_clk, i_rst_n, r_out_vld && r_evd, r_ev)
    `PLRU_ASSERT_IMPL(a_evtag_zero, i_clk, i_rst_n, r_out_vld && !r_ev, r_evtag == '0)

endmodule

// File: bench/plru_cache_checker.sv
// result checker for the pseudo-lru cache tag model: watches both channels,
// predicts every lookup outcome and compares it field by field
// depends on plru_pkg and the plru_req_if / plru_rsp_if interfaces
module plru_cache_checker
    import plru_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    plru_req_if  i_req,
    plru_rsp_if  i_rsp,
    output int   o_pending,
    output int   o_errors
);

    localparam int EXP_DEPTH = 16;
    localparam int EXP_PTR_W = $clog2(EXP_DEPTH);

    // everything one access reports
    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 evicted;
        logic                 evicted_dirty;
        t_tag                 evicted_tag;
        t_stats               stats;
    } t_outcome;

    // predicted cache contents
    t_tag              line_tag [NSETS][WAYS];
    logic              line_vld [NSETS][WAYS];
    logic              line_dty [NSETS][WAYS];
    logic [TREE_W-1:0] plru_bits [NSETS];
    t_stats            tally;

    // expected outcomes in flight, oldest at the head
    t_outcome             exp_store [EXP_DEPTH];
    logic [EXP_PTR_W-1:0] exp_head;
    logic [EXP_PTR_W-1:0] exp_tail;
    int                   exp_count = 0;
    int                   mismatches = 0;
    int                   results_seen = 0;

    assign o_errors = mismatches;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    // one access: lookup, fill or replace, tree update, counters
    function automatic t_outcome cache_lookup(logic cmd, logic [ADDR_W-1:0] addr);
        int unsigned set_idx;
        int unsigned used;
        int unsigned node;
        int unsigned leaf;
        t_tag        tg;
        logic        found;
        logic        bit_now;
        logic        from_left;
        t_outcome    res;

        set_idx = 32'((addr >> OFFSET_BITS) & ADDR_W'(NSETS - 1));
        tg      = t_tag'(addr >> (OFFSET_BITS + SET_BITS));
        res     = '0;
        used    = 0;
        found   = 1'b0;

        if (cmd == CMD_WRITE) begin
            tally.wr_acc += 1;
        end else begin
            tally.rd_acc += 1;
        end

        // tag search
        for (int w = 0; w < WAYS; w++) begin
            if (!found && line_vld[set_idx][w] && line_tag[set_idx][w] == tg) begin
                found = 1'b1;
                used  = w;
            end
        end
        res.hit = found;

        if (found) begin
            line_dty[set_idx][used] = line_dty[set_idx][used] | cmd;
        end else begin
            if (cmd == CMD_WRITE) begin
                tally.wr_miss += 1;
            end else begin
                tally.rd_miss += 1;
            end
            // lowest free way first
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !line_vld[set_idx][w]) begin
                    found = 1'b1;
                    used  = w;
                end
            end
            // full set: walk the tree from the root
            if (!found) begin
                node = 0;
                leaf = 0;
                for (int i = 0; i < TREE_L; i++) begin
                    bit_now = plru_bits[set_idx][node];
                    leaf    = (leaf << 1) | bit_now;
                    node    = 2 * node + 1 + bit_now;
                end
                used                = leaf % WAYS;
                res.evicted         = 1'b1;
                res.evicted_dirty   = line_dty[set_idx][used];
                res.evicted_tag     = line_tag[set_idx][used];
                if (line_dty[set_idx][used]) begin
                    tally.dirty_ev += 1;
                end else begin
                    tally.clean_ev += 1;
                end
            end
            line_vld[set_idx][used] = 1'b1;
            line_tag[set_idx][used] = tg;
            line_dty[set_idx][used] = cmd;
        end

        // point the path away from the used way
        node = used + (1 << TREE_L) - 1;
        while (node > 0) begin
            from_left = node[0];
            node      = (node - 1) / 2;
            plru_bits[set_idx][node] = from_left;
        end

        res.way   = WAY_OUT_W'(used);
        res.stats = tally;
        return res;
    endfunction

    // watch the channels
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            for (int s = 0; s < NSETS; s++) begin
                plru_bits[s] = '0;
                for (int w = 0; w < WAYS; w++) begin
                    line_vld[s][w] = 1'b0;
                    line_dty[s][w] = 1'b0;
                end
            end
            tally     = '0;
            exp_head  = '0;
            exp_tail  = '0;
            exp_count = 0;
            o_pending <= 0;
        end else begin
            // result transaction
            if (i_rsp.valid && i_rsp.ready) begin
                got.hit                  = i_rsp.hit;
                got.way                  = i_rsp.way;
                got.evicted              = i_rsp.evicted;
                got.evicted_dirty        = i_rsp.evicted_dirty;
                got.evicted_tag          = i_rsp.evicted_tag;
                got.stats.rd_acc         = i_rsp.read_accesses;
                got.stats.wr_acc         = i_rsp.write_accesses;
                got.stats.rd_miss        = i_rsp.read_misses;
                got.stats.wr_miss        = i_rsp.write_misses;
                got.stats.clean_ev       = i_rsp.clean_evictions;
                got.stats.dirty_ev       = i_rsp.dirty_evictions;
                if (exp_count == 0) begin
                    report_mismatch("result with nothing outstanding", 64'(got.way), '0);
                end else begin
                    want      = exp_store[exp_head];
                    exp_head  = exp_head + 1'b1;
                    exp_count = exp_count - 1;
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.way !== want.way)
                        report_mismatch("way", 64'(got.way), 64'(want.way));
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
                    if (got.evicted_dirty !== want.evicted_dirty)
                        report_mismatch("evicted_dirty", 64'(got.evicted_dirty),
                                        64'(want.evicted_dirty));
                    if (got.evicted_tag !== want.evicted_tag)
                        report_mismatch("evicted_tag", 64'(got.evicted_tag),
                                        64'(want.evicted_tag));
                    if (got.stats.rd_acc !== want.stats.rd_acc)
                        report_mismatch("read_accesses", 64'(got.stats.rd_acc),
                                        64'(want.stats.rd_acc));
                    if (got.stats.wr_acc !== want.stats.wr_acc)
                        report_mismatch("write_accesses", 64'(got.stats.wr_acc),
                                        64'(want.stats.wr_acc));
                    if (got.stats.rd_miss !== want.stats.rd_miss)
                        report_mismatch("read_misses", 64'(got.stats.rd_miss),
                                        64'(want.stats.rd_miss));
                    if (got.stats.wr_miss !== want.stats.wr_miss)
                        report_mismatch("write_misses", 64'(got.stats.wr_miss),
                                        64'(want.stats.wr_miss));
                    if (got.stats.clean_ev !== want.stats.clean_ev)
                        report_mismatch("clean_evictions", 64'(got.stats.clean_ev),
                                        64'(want.stats.clean_ev));
                    if (got.stats.dirty_ev !== want.stats.dirty_ev)
                        report_mismatch("dirty_evictions", 64'(got.stats.dirty_ev),
                                        64'(want.stats.dirty_ev));
                end
                results_seen++;
            end
            // access transaction
            if (i_req.valid && i_req.ready) begin
                if (exp_count == EXP_DEPTH) begin
                    report_mismatch("too many transactions outstanding", 64'(exp_count),
                                    64'(EXP_DEPTH));
                end else begin
                    exp_store[exp_tail] = cache_lookup(i_req.command, i_req.address);
                    exp_tail            = exp_tail + 1'b1;
                    exp_count           = exp_count + 1;
                end
            end
            o_pending <= exp_count;
        end
    end

endmodule

// File: bench/tb.sv
// testbench top for the pseudo-lru cache tag model: drives access transactions,
// paces the result channel and gives the verdict
// depends on plru_pkg, the channel interfaces, the block and plru_cache_checker
module tb;
    import plru_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int POOL_SIZE   = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asked   = 0;
    int hold_granted = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int pending;
    int errors;

    t_tag tag_pool [POOL_SIZE];

    plru_req_if req_if ();
    plru_rsp_if rsp_if ();

    plru_set_assoc_cache_model_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    plru_cache_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .i_rsp     (rsp_if),
        .o_pending (pending),
        .o_errors  (errors)
    );

    always #1 i_clk = ~i_clk;

    // result side pacing, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_if.ready  <= 1'b0;
        end else if (hold_asked != hold_granted) begin
            hold_granted  <= hold_granted + 1;
            hold_left     <= HOLD_CYCLES;
            rsp_if.ready  <= 1'b0;
        end else begin
            rsp_if.ready  <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("plru_set_assoc_cache_model_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // place a tag and set into an address, keeping the other bits from noise
    function automatic logic [ADDR_W-1:0] make_addr(logic [ADDR_W-1:0] noise, t_tag tg,
                                                    int unsigned set_idx);
        logic [ADDR_W-1:0] field_mask;
        field_mask = ((ADDR_W'(1) << (OFFSET_BITS + SET_BITS + TAG_W)) - 1)
                   & ~((ADDR_W'(1) << OFFSET_BITS) - 1);
        return (noise & ~field_mask)
             | (ADDR_W'(tg) << (OFFSET_BITS + SET_BITS))
             | (ADDR_W'(set_idx % NSETS) << OFFSET_BITS);
    endfunction

    // mostly a few hot sets and a small tag pool so sets fill and evict
    function automatic logic [ADDR_W-1:0] rand_address();
        t_tag        tg;
        int unsigned set_idx;
        if ($urandom_range(99) < 75) begin
            tg = tag_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            tg = $urandom;
        end
        case ($urandom_range(9))
            0, 1, 2: set_idx = 0;
            3, 4:    set_idx = 1;
            5:       set_idx = NSETS - 1;
            default: set_idx = $urandom_range(NSETS - 1);
        endcase
        return make_addr({$urandom, $urandom}, tg, set_idx);
    endfunction

    // one access transaction, with random gaps in front
    task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.address <= addr;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            send_access(logic'($urandom_range(1)), rand_address());
        end
    endtask

    // address extremes, hits, a full set and a chain of evictions
    task automatic run_directed();
        send_access(CMD_READ, '0);
        send_access(CMD_WRITE, '1);
        send_access(CMD_READ, '1);
        // same tag and set, other offset and high bits: hit that dirties the line
        send_access(CMD_WRITE, make_addr('1, '0, 0));
        for (int t = 1; t < WAYS; t++) begin
            send_access(logic'(t & 1), make_addr({$urandom, $urandom}, t_tag'(t), 0));
        end
        // set 0 is full now, every new tag replaces the tree victim
        for (int t = WAYS; t < 2 * WAYS; t++) begin
            send_access(logic'(t & 1), make_addr({$urandom, $urandom}, t_tag'(t), 0));
        end
        send_access(CMD_WRITE, make_addr('0, '1, NSETS - 1));
        send_access(CMD_READ, make_addr('1, t_tag'(2 * WAYS - 1), 0));
    endtask

    // stimulus and verdict
    initial begin
        req_if.valid   = 1'b0;
        req_if.command = CMD_READ;
        req_if.address = '0;
        foreach (tag_pool[k]) begin
            tag_pool[k] = $urandom;
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;

        repeat (6) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct <= 27;
        rx_idle_pct <= 51;

        run_directed();
        run_random(420);

        // long result hold-off while accesses keep coming, then a full pause
        hold_asked <= hold_asked + 1;
        run_random(20);
        drain();

        tx_idle_pct <= 51;
        rx_idle_pct <= 27;
        run_random(420);

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        run_random(420);

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("plru_set_assoc_cache_model_unit test passed");
        end else begin
            $display("plru_set_assoc_cache_model_unit test failed");
        end
        $finish;
    end

endmodule
